@@ design/cal_pkg.sv @@
// Shared types, codes and constants for the command / acknowledge link controller.
// No dependencies; imported by every module of the block.
package cal_pkg;

	localparam int FRAME_BYTES = 8;
	localparam int IDX_W       = $clog2(FRAME_BYTES);
	localparam int CNT_W       = IDX_W + 1;
	localparam int FRAME_W     = 8 * FRAME_BYTES;
	localparam int WAIT_W      = 10;
	localparam int GAP_W       = 8;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	// Frame bytes and thresholds
	localparam logic [7:0] HDR_VAR_LEN  = 8'hFD;
	localparam logic [7:0] HDR_FIX_LEN  = 8'hEF;
	localparam logic [7:0] CMD_LEN_BYTE = 8'h08;
	localparam logic [7:0] TYPE_NO_SEQ  = 8'h71;
	localparam logic [7:0] TYPE_LONG    = 8'h70;
	localparam logic [7:0] CHAN_BIG_END = 8'h01;
	localparam logic [7:0] MIN_ACK_LEN  = 8'h02;

	// Register map, index of each register
	localparam logic [1:0] REG_LONG_WAIT  = 2'd0;
	localparam logic [1:0] REG_SHORT_WAIT = 2'd1;
	localparam logic [1:0] REG_BYTE_GAP   = 2'd2;

	localparam logic [WAIT_W-1:0] LONG_WAIT_RST  = WAIT_W'(500);
	localparam logic [WAIT_W-1:0] SHORT_WAIT_RST = WAIT_W'(100);
	localparam logic [GAP_W-1:0]  BYTE_GAP_RST   = GAP_W'(20);

	typedef enum logic [1:0] {
		OP_SEND = 2'd0,
		OP_BYTE = 2'd1,
		OP_TICK = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		KIND_FRAME   = 2'd0,
		KIND_ACK     = 2'd1,
		KIND_TIMEOUT = 2'd2
	} kind_t;

	typedef struct packed {
		logic [WAIT_W-1:0] long_wait;
		logic [WAIT_W-1:0] short_wait;
		logic [GAP_W-1:0]  byte_gap;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  channel;
		logic [7:0]  header;
		logic [7:0]  sequence_req;
		logic [7:0]  msg_type;
		logic [7:0]  dev_address;
		logic [15:0] payload;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic               valid;
		kind_t              kind;
		logic [FRAME_W-1:0] frame;
	} result_t;

endpackage

@@ design/command_ack_link_controller_unit.sv @@
// Top level of the command / acknowledge link controller: request register, output register.
// Depends on cal_pkg, cal_regs, cal_frame_build and cal_ack_engine.
//
// Usage:
//   Input channel (in_valid / in_ready) carries one request: op selects a command send,
//   a received link byte, or a timer tick; the command fields matter only for a send.
//   Output channel (out_valid / out_ready) carries a kind code and a 64-bit frame:
//   the command frame to transmit, a good ack frame, or an ack timeout (frame zero).
//   Bytes and ticks that complete nothing give no result.
//   An accepted request is evaluated in the request register; its result is captured in
//   the output register and offered from then on. Throughput is one request per cycle
//   unless the receiver stalls; the single-pass update in cal_ack_engine sets that figure.
//   When the receiver stalls, the pending result holds in the output register, one more
//   request waits in the request register, and in_ready drops after that.
//   Reset clears both registers, the ack buffer, counters and timers and loads the tick
//   registers with 500, 100 and 20. There is no clearing pass; requests are taken at
//   once after reset. The APB port has no wait states (pready is tied high); registers
//   lie at byte addresses 0, 4 and 8.
module command_ack_link_controller_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	// Request channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [7:0]                  channel,
	input  logic [7:0]                  header,
	input  logic [7:0]                  sequence_req,
	input  logic [7:0]                  msg_type,
	input  logic [7:0]                  dev_address,
	input  logic [15:0]                 payload,
	input  logic [7:0]                  rx_byte,
	// Result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [cal_pkg::FRAME_W-1:0] frame,
	// Configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cal_pkg::ADDR_W-1:0]  paddr,
	input  logic [cal_pkg::DATA_W-1:0]  pwdata,
	output logic [cal_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);
	import cal_pkg::*;

	item_t              item_s1;
	logic               valid_s1;
	logic               advance;
	logic               in_acc;
	cfg_t               cfg;
	logic [FRAME_W-1:0] cmd_frame;
	result_t            res;
	logic               out_valid_q;
	kind_t              kind_q;
	logic [FRAME_W-1:0] frame_q;

	assign pready  = 1'b1;
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_acc  = in_valid && in_ready;

	cal_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= '{op: op, channel: channel, header: header,
			             sequence_req: sequence_req, msg_type: msg_type,
			             dev_address: dev_address, payload: payload, rx_byte: rx_byte};
		end
	end

	cal_frame_build u_frame (
		.item  (item_s1),
		.frame (cmd_frame)
	);

	cal_ack_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (advance),
		.item      (item_s1),
		.cfg       (cfg),
		.cmd_frame (cmd_frame),
		.res       (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind_q  <= res.kind;
			frame_q <= res.frame;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign frame     = frame_q;

`ifndef SYNTHESIS
	a_timeout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_TIMEOUT |-> frame_q == '0)
		else $error("timeout result with nonzero frame");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !in_ready)
		else $error("request taken while stage is stalled");
`endif

endmodule

@@ design/cal_regs.sv @@
// Configuration registers behind the APB-style port: wait and gap tick limits.
// Depends on cal_pkg.
module cal_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cal_pkg::ADDR_W-1:0]  paddr,
	input  logic [cal_pkg::DATA_W-1:0]  pwdata,
	output logic [cal_pkg::DATA_W-1:0]  prdata,
	output cal_pkg::cfg_t               cfg
);
	import cal_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	// Register writes on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_wait  <= LONG_WAIT_RST;
			cfg_q.short_wait <= SHORT_WAIT_RST;
			cfg_q.byte_gap   <= BYTE_GAP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_LONG_WAIT:  cfg_q.long_wait  <= pwdata[WAIT_W-1:0];
				REG_SHORT_WAIT: cfg_q.short_wait <= pwdata[WAIT_W-1:0];
				REG_BYTE_GAP:   cfg_q.byte_gap   <= pwdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		case (reg_idx)
			REG_LONG_WAIT:  prdata = DATA_W'(cfg_q.long_wait);
			REG_SHORT_WAIT: prdata = DATA_W'(cfg_q.short_wait);
			REG_BYTE_GAP:   prdata = DATA_W'(cfg_q.byte_gap);
			default:        prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ design/cal_frame_build.sv @@
// Command frame assembly: header, length, sequence, type, address, data, XOR check byte.
// Depends on cal_pkg.
module cal_frame_build (
	input  cal_pkg::item_t               item,
	output logic [cal_pkg::FRAME_W-1:0]  frame
);
	import cal_pkg::*;

	logic [7:0] fb [FRAME_BYTES];
	logic       big_end;
	logic [7:0] chk;

	assign big_end = (item.channel == CHAN_BIG_END);

	always_comb begin
		fb[0] = item.header;
		fb[1] = CMD_LEN_BYTE;
		// Sequence is dropped for this type on the big-endian channel
		fb[2] = (big_end && item.msg_type == TYPE_NO_SEQ) ? 8'h00 : item.sequence_req;
		fb[3] = item.msg_type;
		fb[4] = item.dev_address;
		fb[5] = big_end ? item.payload[15:8] : item.payload[7:0];
		fb[6] = big_end ? item.payload[7:0]  : item.payload[15:8];
		chk   = '0;
		for (int k = 0; k < FRAME_BYTES - 1; k++) begin
			chk = chk ^ fb[k];
		end
		fb[FRAME_BYTES-1] = chk;
	end

	always_comb begin
		for (int k = 0; k < FRAME_BYTES; k++) begin
			frame[8*k +: 8] = fb[k];
		end
	end

endmodule

@@ design/cal_ack_engine.sv @@
// Conversation state: ack header hunt, ack frame collection and check, wait and gap timers.
// Depends on cal_pkg; takes the command frame from cal_frame_build.
module cal_ack_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         go,
	input  cal_pkg::item_t               item,
	input  cal_pkg::cfg_t                cfg,
	input  logic [cal_pkg::FRAME_W-1:0]  cmd_frame,
	output cal_pkg::result_t             res
);
	import cal_pkg::*;

	logic [7:0]        ack_buf_q [FRAME_BYTES];
	logic [CNT_W-1:0]  ack_count_q;
	logic              collecting_q;
	logic              waiting_q;
	logic [WAIT_W-1:0] wait_left_q;
	logic [GAP_W-1:0]  gap_left_q;

	logic [7:0]        ack_buf_d [FRAME_BYTES];
	logic [CNT_W-1:0]  ack_count_d;
	logic              collecting_d;
	logic              waiting_d;
	logic [WAIT_W-1:0] wait_left_d;
	logic [GAP_W-1:0]  gap_left_d;

	// Buffer with the incoming byte written in, and its running XOR
	logic [7:0]             nb [FRAME_BYTES];
	logic [7:0]             px [FRAME_BYTES];
	logic [FRAME_BYTES-1:0] chk_ok;
	logic [FRAME_W-1:0]     nb_packed;
	logic [CNT_W-1:0]       cnt_inc;
	logic [7:0]             ack_len;
	logic [IDX_W-1:0]       last_idx;
	logic [WAIT_W-1:0]      wait_dec;
	logic [GAP_W-1:0]       gap_dec;
	logic                   is_hdr;

	always_comb begin
		for (int k = 0; k < FRAME_BYTES; k++) begin
			nb[k] = (ack_count_q[IDX_W-1:0] == IDX_W'(k)) ? item.rx_byte : ack_buf_q[k];
		end
		px[0] = '0;
		for (int k = 1; k < FRAME_BYTES; k++) begin
			px[k] = px[k-1] ^ nb[k-1];
		end
		for (int k = 0; k < FRAME_BYTES; k++) begin
			chk_ok[k]         = (nb[k] == px[k]);
			nb_packed[8*k +: 8] = nb[k];
		end
	end

	assign cnt_inc  = ack_count_q + CNT_W'(1);
	assign ack_len  = nb[1];
	assign last_idx = ack_len[IDX_W-1:0] - IDX_W'(1);
	assign wait_dec = (wait_left_q != '0) ? wait_left_q - WAIT_W'(1) : '0;
	assign gap_dec  = (gap_left_q != '0) ? gap_left_q - GAP_W'(1) : '0;
	assign is_hdr   = (item.rx_byte == HDR_VAR_LEN) || (item.rx_byte == HDR_FIX_LEN);

	// Next state and result for the item in the stage
	always_comb begin
		ack_buf_d    = ack_buf_q;
		ack_count_d  = ack_count_q;
		collecting_d = collecting_q;
		waiting_d    = waiting_q;
		wait_left_d  = wait_left_q;
		gap_left_d   = gap_left_q;
		res          = '{valid: 1'b0, kind: KIND_FRAME, frame: '0};

		case (item.op)
			OP_SEND: begin
				wait_left_d  = (item.msg_type >= TYPE_LONG) ? cfg.long_wait : cfg.short_wait;
				waiting_d    = 1'b1;
				collecting_d = 1'b0;
				ack_count_d  = '0;
				gap_left_d   = '0;
				res          = '{valid: 1'b1, kind: KIND_FRAME, frame: cmd_frame};
			end
			OP_BYTE: begin
				if (waiting_q && !collecting_q) begin
					// Header hunt
					if (is_hdr && cfg.byte_gap != '0) begin
						ack_buf_d[0] = item.rx_byte;
						ack_count_d  = CNT_W'(1);
						collecting_d = 1'b1;
						gap_left_d   = cfg.byte_gap;
					end
				end else if (waiting_q) begin
					ack_buf_d   = nb;
					ack_count_d = cnt_inc;
					if (ack_buf_q[0] == HDR_VAR_LEN) begin
						if (cnt_inc == CNT_W'(2) &&
						    (ack_len > CMD_LEN_BYTE || ack_len < MIN_ACK_LEN)) begin
							// Bad length: abort, timeout if the wait already ran out
							collecting_d = 1'b0;
							if (wait_left_q == '0) begin
								waiting_d = 1'b0;
								res       = '{valid: 1'b1, kind: KIND_TIMEOUT, frame: '0};
							end
						end else if (8'(cnt_inc) == ack_len) begin
							collecting_d = 1'b0;
							if (chk_ok[last_idx]) begin
								waiting_d = 1'b0;
								res       = '{valid: 1'b1, kind: KIND_ACK, frame: nb_packed};
							end else if (wait_left_q == '0) begin
								waiting_d = 1'b0;
								res       = '{valid: 1'b1, kind: KIND_TIMEOUT, frame: '0};
							end
						end
					end else if (cnt_inc >= CNT_W'(FRAME_BYTES)) begin
						collecting_d = 1'b0;
						if (chk_ok[FRAME_BYTES-1]) begin
							waiting_d = 1'b0;
							res       = '{valid: 1'b1, kind: KIND_ACK, frame: nb_packed};
						end else if (wait_left_q == '0) begin
							waiting_d = 1'b0;
							res       = '{valid: 1'b1, kind: KIND_TIMEOUT, frame: '0};
						end
					end
				end
			end
			OP_TICK: begin
				if (waiting_q) begin
					wait_left_d = wait_dec;
					if (collecting_q) begin
						gap_left_d = gap_dec;
						// Gap expiry drops the partial frame
						if (gap_dec == '0) begin
							collecting_d = 1'b0;
							if (wait_dec == '0) begin
								waiting_d = 1'b0;
								res       = '{valid: 1'b1, kind: KIND_TIMEOUT, frame: '0};
							end
						end
					end else if (wait_dec == '0) begin
						waiting_d = 1'b0;
						res       = '{valid: 1'b1, kind: KIND_TIMEOUT, frame: '0};
					end
				end
			end
			default: ;
		endcase

		if (!go) begin
			res.valid = 1'b0;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FRAME_BYTES; k++) begin
				ack_buf_q[k] <= '0;
			end
			ack_count_q  <= '0;
			collecting_q <= 1'b0;
			waiting_q    <= 1'b0;
			wait_left_q  <= '0;
			gap_left_q   <= '0;
		end else if (go) begin
			ack_buf_q    <= ack_buf_d;
			ack_count_q  <= ack_count_d;
			collecting_q <= collecting_d;
			waiting_q    <= waiting_d;
			wait_left_q  <= wait_left_d;
			gap_left_q   <= gap_left_d;
		end
	end

`ifndef SYNTHESIS
	a_collect_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> waiting_q)
		else $error("collecting outside a wait");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ack_count_q <= CNT_W'(FRAME_BYTES))
		else $error("ack byte count past frame size");
	a_ack_ends_wait: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.kind == KIND_ACK |=> !waiting_q && !collecting_q)
		else $error("good ack did not end the wait");
`endif

endmodule
